[design/plvp_pkg.sv]
// ----------------------------------------------------------------------------
// plvp_pkg: shared types and constants of the posting list VLQ parser
// Parser phases, list kinds, result kind codes, configuration register
// indexes and the configuration bundle passed to the parser core.
// ----------------------------------------------------------------------------
package plvp_pkg;

	localparam int BYTE_BITS      = 8;
	localparam int KIND_BITS      = 3;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 8;
	localparam int GROUP_BITS     = 7;

	localparam logic [KIND_BITS-1:0] KIND_INDEX = 3'd0;
	localparam logic [KIND_BITS-1:0] KIND_OCC   = 3'd1;
	localparam logic [KIND_BITS-1:0] KIND_RANK  = 3'd2;
	localparam logic [KIND_BITS-1:0] KIND_META  = 3'd3;
	localparam logic [KIND_BITS-1:0] KIND_POS   = 3'd4;
	localparam logic [KIND_BITS-1:0] KIND_END   = 3'd5;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_STOP     = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_CONTINUE = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_META     = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_POS      = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_POS_EN   = 3'd4;

	localparam logic [BYTE_BITS-1:0] RST_STOP     = 8'd0;
	localparam logic [BYTE_BITS-1:0] RST_CONTINUE = 8'd1;
	localparam logic [BYTE_BITS-1:0] RST_META     = 8'd2;
	localparam logic [BYTE_BITS-1:0] RST_POS      = 8'd3;

	typedef enum logic [2:0] {
		PH_INDEX  = 3'd0,
		PH_OCC    = 3'd1,
		PH_RANK   = 3'd2,
		PH_MARKER = 3'd3,
		PH_LIST   = 3'd4,
		PH_DONE   = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		LK_META = 2'd0,
		LK_POS  = 2'd1,
		LK_SKIP = 2'd2
	} list_kind_t;

	typedef struct packed {
		logic [BYTE_BITS-1:0] stop_code;
		logic [BYTE_BITS-1:0] continue_code;
		logic [BYTE_BITS-1:0] meta_list_code;
		logic [BYTE_BITS-1:0] pos_list_code;
		logic                 pos_enable;
	} cfg_t;

endpackage

[design/plvp_cfg.sv]
// ----------------------------------------------------------------------------
// plvp_cfg: configuration registers
// Holds the marker codes and the position list enable, written through a
// plain write port.
// ----------------------------------------------------------------------------
module plvp_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [plvp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [plvp_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	output plvp_pkg::cfg_t                      cfg
);
	import plvp_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stop_code      <= RST_STOP;
			cfg_q.continue_code  <= RST_CONTINUE;
			cfg_q.meta_list_code <= RST_META;
			cfg_q.pos_list_code  <= RST_POS;
			cfg_q.pos_enable     <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_STOP:     cfg_q.stop_code      <= cfg_data;
				CFG_CONTINUE: cfg_q.continue_code  <= cfg_data;
				CFG_META:     cfg_q.meta_list_code <= cfg_data;
				CFG_POS:      cfg_q.pos_list_code  <= cfg_data;
				CFG_POS_EN:   cfg_q.pos_enable     <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[design/plvp_in.sv]
// ----------------------------------------------------------------------------
// plvp_in: input stage
// Registers one accepted input beat and keeps it until the parser core
// consumes it.
// ----------------------------------------------------------------------------
module plvp_in (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [plvp_pkg::BYTE_BITS-1:0] data_byte,
	input  logic                           list_start,
	input  logic                           advance,
	output logic                           valid_s1,
	output logic [plvp_pkg::BYTE_BITS-1:0] byte_s1,
	output logic                           start_s1
);
	import plvp_pkg::*;

	logic accept;

	assign in_ready = !valid_s1 || advance;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1  <= data_byte;
			start_s1 <= list_start;
		end
	end

endmodule

[design/plvp_core.sv]
// ----------------------------------------------------------------------------
// plvp_core: parser state and result register
// Applies one byte to the parser state and loads the
// result, if the byte completes one, into the output register.
// ----------------------------------------------------------------------------
module plvp_core #(
	parameter int VALUE_BITS = 32,
	parameter int COUNT_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  plvp_pkg::cfg_t                 cfg,
	input  logic                           valid_s1,
	input  logic [plvp_pkg::BYTE_BITS-1:0] byte_s1,
	input  logic                           start_s1,
	output logic                           advance,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [plvp_pkg::KIND_BITS-1:0] kind,
	output logic [VALUE_BITS-1:0]          value,
	output logic [COUNT_BITS-1:0]          entry_count,
	output logic                           list_end,
	output logic                           overflow
);
	import plvp_pkg::*;

	phase_t                  phase_q, ph, phase_n;
	list_kind_t              lk_q, lk, lk_n;
	logic [VALUE_BITS-1:0]   acc_q, acc, acc_n, g_acc;
	logic                    ovf_q, ovf, ovf_n, g_ovf;
	logic                    started_q, started, started_n;
	logic [COUNT_BITS-1:0]   ent_q, ent, ent_n;
	logic [VALUE_BITS+GROUP_BITS-1:0] shifted;
	logic                    g_done, is_stop, is_cont, is_meta, is_pos;

	logic                    res_v, res_end, res_ovf;
	logic [KIND_BITS-1:0]    res_kind;
	logic [VALUE_BITS-1:0]   res_value;

	logic                    out_valid_s2;
	logic [KIND_BITS-1:0]    kind_s2;
	logic [VALUE_BITS-1:0]   value_s2;
	logic [COUNT_BITS-1:0]   count_s2;
	logic                    end_s2, ovf_s2;

	assign advance = valid_s1 && (!out_valid_s2 || out_ready);

	assign ph      = start_s1 ? PH_INDEX : phase_q;
	assign lk      = start_s1 ? LK_META : lk_q;
	assign acc     = start_s1 ? '0 : acc_q;
	assign ovf     = start_s1 ? 1'b0 : ovf_q;
	assign started = start_s1 ? 1'b0 : started_q;
	assign ent     = start_s1 ? '0 : ent_q;

	assign is_stop = byte_s1 == cfg.stop_code;
	assign is_cont = byte_s1 == cfg.continue_code;
	assign is_meta = byte_s1 == cfg.meta_list_code;
	assign is_pos  = (byte_s1 == cfg.pos_list_code) && cfg.pos_enable;
	assign g_done  = !byte_s1[BYTE_BITS-1];
	assign shifted = {acc, byte_s1[GROUP_BITS-1:0]};

	always_comb begin
		g_acc = acc;
		g_ovf = ovf;
		if (!ovf) begin
			if (acc[VALUE_BITS-1 -: GROUP_BITS] != '0) begin
				g_acc = '1;
				g_ovf = 1'b1;
			end else begin
				g_acc = shifted[VALUE_BITS-1:0];
			end
		end
	end

	always_comb begin
		phase_n = ph;
		case (ph)
			PH_INDEX:  if (g_done) phase_n = PH_OCC;
			PH_OCC:    if (g_done) phase_n = PH_RANK;
			PH_RANK:   if (g_done) phase_n = PH_MARKER;
			PH_MARKER: begin
				if (is_stop) phase_n = PH_DONE;
				else if (is_cont) phase_n = PH_INDEX;
				else phase_n = PH_LIST;
			end
			PH_LIST:   if (!started && is_stop) phase_n = PH_MARKER;
			PH_DONE:   phase_n = PH_DONE;
			default:   phase_n = PH_INDEX;
		endcase
	end

	always_comb begin
		acc_n     = acc;
		ovf_n     = ovf;
		started_n = started;
		lk_n      = lk;
		ent_n     = ent;
		res_v     = 1'b0;
		res_kind  = KIND_INDEX;
		res_value = g_acc;
		res_end   = 1'b0;
		res_ovf   = g_ovf;
		case (ph)
			PH_INDEX, PH_OCC, PH_RANK: begin
				if (ph == PH_INDEX && !started && !(&ent)) begin
					ent_n = ent + {{(COUNT_BITS-1){1'b0}}, 1'b1};
				end
				if (g_done) begin
					res_v     = 1'b1;
					res_kind  = (ph == PH_INDEX) ? KIND_INDEX :
						(ph == PH_OCC) ? KIND_OCC : KIND_RANK;
					acc_n     = '0;
					ovf_n     = 1'b0;
					started_n = 1'b0;
				end else begin
					acc_n     = g_acc;
					ovf_n     = g_ovf;
					started_n = 1'b1;
				end
			end
			PH_MARKER: begin
				res_value = '0;
				res_ovf   = 1'b0;
				res_kind  = KIND_END;
				if (is_stop) begin
					res_v   = 1'b1;
					res_end = 1'b1;
				end else if (is_cont) begin
					res_v = 1'b1;
				end else begin
					if (is_meta) lk_n = LK_META;
					else if (is_pos) lk_n = LK_POS;
					else lk_n = LK_SKIP;
					acc_n     = '0;
					ovf_n     = 1'b0;
					started_n = 1'b0;
				end
			end
			PH_LIST: begin
				if (started || !is_stop) begin
					if (g_done) begin
						res_v     = (lk == LK_META) || (lk == LK_POS);
						res_kind  = (lk == LK_META) ? KIND_META : KIND_POS;
						acc_n     = '0;
						ovf_n     = 1'b0;
						started_n = 1'b0;
					end else begin
						acc_n     = g_acc;
						ovf_n     = g_ovf;
						started_n = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_INDEX;
			lk_q      <= LK_META;
			acc_q     <= '0;
			ovf_q     <= 1'b0;
			started_q <= 1'b0;
			ent_q     <= '0;
		end else if (advance) begin
			phase_q   <= phase_n;
			lk_q      <= lk_n;
			acc_q     <= acc_n;
			ovf_q     <= ovf_n;
			started_q <= started_n;
			ent_q     <= ent_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= res_v;
		end else if (out_ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_v) begin
			kind_s2  <= res_kind;
			value_s2 <= res_value;
			count_s2 <= ent_n;
			end_s2   <= res_end;
			ovf_s2   <= res_ovf;
		end
	end

	assign out_valid   = out_valid_s2;
	assign kind        = kind_s2;
	assign value       = value_s2;
	assign entry_count = count_s2;
	assign list_end    = end_s2;
	assign overflow    = ovf_s2;

endmodule

[design/posting_list_vlq_parser.sv]
// ----------------------------------------------------------------------------
// posting_list_vlq_parser: VLQ posting list decoder
// A byte is registered in the input stage, its result in the output register.
// Throughput: one byte per cycle while each result is accepted.
// While a result waits unaccepted the parser holds, and the input register
// takes at most one more byte beat.
// Reset clears the parser state and loads the default marker codes.
// ----------------------------------------------------------------------------
module posting_list_vlq_parser #(
	parameter int VALUE_BITS = 32,
	parameter int COUNT_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [plvp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [plvp_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [plvp_pkg::BYTE_BITS-1:0]      data_byte,
	input  logic                                list_start,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [plvp_pkg::KIND_BITS-1:0]      kind,
	output logic [VALUE_BITS-1:0]               value,
	output logic [COUNT_BITS-1:0]               entry_count,
	output logic                                list_end,
	output logic                                overflow
);
	import plvp_pkg::*;

	cfg_t                 cfg;
	logic                 advance;
	logic                 valid_s1;
	logic [BYTE_BITS-1:0] byte_s1;
	logic                 start_s1;

	plvp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	plvp_in u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.list_start (list_start),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.byte_s1    (byte_s1),
		.start_s1   (start_s1)
	);

	plvp_core #(
		.VALUE_BITS (VALUE_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.valid_s1    (valid_s1),
		.byte_s1     (byte_s1),
		.start_s1    (start_s1),
		.advance     (advance),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.value       (value),
		.entry_count (entry_count),
		.list_end    (list_end),
		.overflow    (overflow)
	);

endmodule
